FILE: hdl/rtwi_pkg.sv
package rtwi_pkg;

  // Prescaler and timer constants.
  localparam int unsigned LINE_CYCLES = 455;
  localparam int unsigned TICK_CYCLES = 1024;
  localparam int unsigned TIMER_BIT   = 2;
  localparam int unsigned MASK_BITS   = 7;

  localparam int unsigned PHASE_W = 10;

  // The phase arithmetic wraps at the width of the phase register.
  localparam logic [PHASE_W-1:0] LINE_STEP = PHASE_W'(LINE_CYCLES % 1024);
  localparam logic [PHASE_W-1:0] TICK_STEP = PHASE_W'(TICK_CYCLES % 1024);

  // Byte returned by a status read while the timer interrupt is pending.
  localparam logic [7:0] TIMER_IRQ_BYTE = 8'(8'd1 << (TIMER_BIT % 8));
  // Mask register bits that can really be stored.
  localparam logic [2:0] MASK_STORE = 3'(MASK_BITS & 7);
  // Latch bits that show through in a mask register read.
  localparam logic [7:0] MASK_READ_KEEP = ~8'(MASK_BITS & 255);

  // Address decode.
  localparam logic [12:0] LATCH_LO    = 13'h0800;
  localparam logic [12:0] LATCH_HI    = 13'h1800;
  localparam logic [4:0]  PAGE_TIMER  = 5'h0C;
  localparam logic [4:0]  PAGE_IRQ    = 5'h14;
  localparam logic [1:0]  IRQ_OFS_MASK   = 2'd2;
  localparam logic [1:0]  IRQ_OFS_STATUS = 2'd3;
  localparam logic [7:0]  OPEN_BUS    = 8'hFF;
  localparam logic [7:0]  COUNT_WRAP  = 8'h7F;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_item_t;

endpackage

FILE: hdl/reload_timer_with_irq_regs_unit.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// in_      | input     | in_valid/in_stall  | in_item: func, addr, write_data
// out_     | output    | out_valid/out_stall| out_item: read_data, timer_irq
//
// One transaction is taken every cycle while the result channel does not stall; each
// one gives exactly one result transaction, which passes through the input register
// and then the register-update logic into the result register.
// The rate is set by the single pass through the state-update logic, which
// reads and writes every timer and interrupt register in the same cycle.
// Reset (rst_n low at a clock edge) clears all timer, mask, status and latch
// state and empties both pipeline registers.
// A stall on the result channel holds the result register; the input side
// then stalls only once its own register is also full.
module reload_timer_with_irq_regs_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtwi_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rtwi_pkg::out_item_t out_item
);
  import rtwi_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      fire;
  out_item_t result;

  // The held transaction is processed when the result register is empty or
  // is being emptied in this very cycle; processing updates the timer state
  // and loads the result register at the same edge.
  assign fire     = item_valid && (!out_valid || !out_stall);
  // The input register can take a new transaction whenever its present one
  // moves on, or it holds nothing.
  assign in_stall = item_valid && !fire;

  rtwi_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item)
  );

  // Prescaler, down counter, reload, run flag, mask, status and I/O latch,
  // all updated in one pass for each transaction.
  rtwi_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  rtwi_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/rtwi_in_stage.sv
module rtwi_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rtwi_pkg::in_item_t in_item,
  output logic              item_valid,
  output rtwi_pkg::in_item_t item
);
  import rtwi_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // The register refills whenever its content moves on (the stall is low).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hdl/rtwi_core.sv
module rtwi_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rtwi_pkg::in_item_t  item,
  output rtwi_pkg::out_item_t result
);
  import rtwi_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         count_r, count_nxt;
  logic [6:0]         reload_r, reload_nxt;
  logic               run_r, run_nxt;
  logic [2:0]         mask_r, mask_nxt;
  logic               pending_r, pending_nxt;
  logic [7:0]         latch_r, latch_nxt;

  logic               in_range;
  logic               page_timer;
  logic               page_irq;
  logic [1:0]         ofs;
  logic               borrow;
  logic [PHASE_W-1:0] phase_dec;
  logic [7:0]         count_base;
  logic [7:0]         rd;

  always_comb begin
    in_range   = (item.addr >= LATCH_LO) && (item.addr < LATCH_HI);
    page_timer = (item.addr[12:8] == PAGE_TIMER);
    page_irq   = (item.addr[12:8] == PAGE_IRQ);
    ofs        = item.addr[1:0];
    borrow     = (phase_r < LINE_STEP);
    phase_dec  = phase_r - LINE_STEP;
    count_base = (count_r > COUNT_WRAP) ? {1'b0, reload_r} : count_r;

    phase_nxt   = phase_r;
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    run_nxt     = run_r;
    mask_nxt    = mask_r;
    pending_nxt = pending_r;
    latch_nxt   = latch_r;
    rd          = OPEN_BUS;

    case (item.func)
      FUNC_TICK: begin
        phase_nxt = borrow ? (phase_dec + TICK_STEP) : phase_dec;
        if (borrow && run_r) begin
          if (count_r > COUNT_WRAP) begin
            pending_nxt = 1'b1;
          end
          count_nxt = count_base - 8'd1;
        end
      end
      FUNC_READ: begin
        if (in_range) begin
          rd = latch_r;
        end
        if (page_timer) begin
          rd = count_r | (latch_r & 8'h80);
        end else if (page_irq) begin
          if (ofs == IRQ_OFS_MASK) begin
            rd = {5'd0, mask_r} | (latch_r & MASK_READ_KEEP);
          end else if (ofs == IRQ_OFS_STATUS) begin
            rd          = pending_r ? TIMER_IRQ_BYTE : 8'h00;
            pending_nxt = 1'b0;
          end
        end
        if (in_range) begin
          latch_nxt = rd;
        end
      end
      FUNC_WRITE: begin
        if (in_range) begin
          latch_nxt = item.write_data;
        end
        if (page_timer) begin
          if (!ofs[0]) begin
            reload_nxt = item.write_data[6:0];
          end else begin
            if (item.write_data[0] && !run_r) begin
              count_nxt = {1'b0, reload_r};
            end
            run_nxt = item.write_data[0];
          end
        end else if (page_irq) begin
          if (ofs == IRQ_OFS_MASK) begin
            mask_nxt = item.write_data[2:0] & MASK_STORE;
          end else if (ofs == IRQ_OFS_STATUS) begin
            pending_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    result.read_data = rd;
    result.timer_irq = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      count_r   <= '0;
      reload_r  <= '0;
      run_r     <= 1'b0;
      mask_r    <= '0;
      pending_r <= 1'b0;
      latch_r   <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      run_r     <= run_nxt;
      mask_r    <= mask_nxt;
      pending_r <= pending_nxt;
      latch_r   <= latch_nxt;
    end
  end

endmodule

FILE: hdl/rtwi_out_stage.sv
module rtwi_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rtwi_pkg::out_item_t result,
  input  logic                out_stall,
  output logic                out_valid,
  output rtwi_pkg::out_item_t out_item
);
  import rtwi_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
